// ----- rtl/core/ppp_pkg.sv -----
// Shared types and constants of the perspective point projector.
`default_nettype none

package ppp_pkg;

    // Coordinate format and derived widths
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int SCALE_W     = 32;
    localparam int SCALE_FRAC  = 24;
    localparam int SPLIT_W     = 16;
    localparam int HI_W        = DIFF_W - SPLIT_W + SCALE_W;
    localparam int LO_W        = SPLIT_W + SCALE_W;
    localparam int SPROD_W     = DIFF_W + SCALE_W;
    localparam int ENTRY_W     = 16;
    localparam int ENTRY_FRAC  = 12;
    localparam int PROD_W      = ENTRY_W + COORD_WIDTH;
    localparam int TERM_W      = PROD_W - ENTRY_FRAC;
    localparam int ACC_W       = TERM_W + 2;
    localparam int NUM_W       = COORD_WIDTH + FRAC_BITS;
    localparam int DIV_STEPS   = FRAC_BITS + 1;
    localparam int Q_W         = DIV_STEPS;
    localparam int SCR_W       = 16;
    localparam int ROWS        = 4;
    localparam int LANES       = 3;

    // Queue sizes
    localparam int MID_DEPTH   = 4;
    localparam int MID_AW      = 2;
    localparam int OUT_DEPTH   = 32;
    localparam int OUT_AW      = 5;

    // Back pipeline: eight arithmetic stages, then one stage per quotient bit
    localparam int FRONT_STAGES = 8;
    localparam int PIPE_LEN     = FRONT_STAGES + DIV_STEPS;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 4'd7;

    // Reject codes
    localparam logic [1:0] REJ_NONE     = 2'd0;
    localparam logic [1:0] REJ_OVERFLOW = 2'd1;
    localparam logic [1:0] REJ_BEHIND   = 2'd2;
    localparam logic [1:0] REJ_OUTSIDE  = 2'd3;

    typedef struct packed {
        logic [ROWS-1:0][CFG_DATA_W-1:0]   row;
        logic [LANES-1:0][COORD_WIDTH-1:0] org;
        logic [SCALE_W-1:0]                scale;
    } cfg_t;

    typedef struct packed {
        logic [LANES-1:0][DIFF_W-1:0] mag;
        logic [LANES-1:0]             neg;
        logic                         szero;
    } front_item_t;

    typedef struct packed {
        logic             visible;
        logic [1:0]       code;
        logic [SCR_W-1:0] u;
        logic [SCR_W-1:0] v;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppp_front.sv -----
// Input stage: origin subtraction and sign/magnitude split of each beat.
`default_nettype none

module ppp_front
    import ppp_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [LANES-1:0][COORD_WIDTH-1:0] point,
    input  wire cfg_t                          cfg,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output front_item_t                        q_data
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic signed [LANES-1:0][DIFF_W-1:0]   diff_reg;
    logic                                  szero_reg;

    // Take a new beat when the stage is empty or drains this cycle
    assign in_ready   = !valid_reg || q_ready;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !q_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the difference of point and origin
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                diff_reg[i] <= DIFF_W'($signed(point[i])) - DIFF_W'($signed(cfg.org[i]));
            end
            szero_reg <= (cfg.scale == '0);
        end
    end

    // Split into sign and magnitude for the queue
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            q_data.neg[i] = diff_reg[i][DIFF_W-1];
            q_data.mag[i] = diff_reg[i][DIFF_W-1] ? (DIFF_W'(0) - diff_reg[i]) : diff_reg[i];
        end
        q_data.szero = szero_reg;
    end

    assign q_valid = valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ppp_queue.sv -----
// Short queue between the front stage and the back pipeline.
`default_nettype none

module ppp_queue
    import ppp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_valid,
    output logic             wr_ready,
    input  wire front_item_t wr_data,
    output logic             rd_valid,
    input  wire logic        rd_ready,
    output front_item_t      rd_data
);

    front_item_t         mem [MID_DEPTH];
    logic [MID_AW-1:0]   wr_ptr_reg;
    logic [MID_AW-1:0]   rd_ptr_reg;
    logic [MID_AW:0]     cnt_reg;
    logic [MID_AW:0]     cnt_next;
    logic                do_wr;
    logic                do_rd;

    assign wr_ready = (cnt_reg != MID_AW'(0) + (MID_AW+1)'(MID_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ppp_back.sv -----
// Back pipeline: scaling, matrix transform, clip checks, divide, viewport map.
`default_nettype none

module ppp_back
    import ppp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire front_item_t q_data,
    output logic             empty,
    input  wire logic        pop,
    output result_t          head
);

    localparam logic [SPROD_W-1:0] SCALE_RND = SPROD_W'(1) << (SCALE_FRAC - 1);
    localparam logic [COORD_WIDTH-1:0] LIM_U = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LIM_S = ACC_W'(LIM_U);
    localparam logic signed [ACC_W-1:0] W_TOL = ACC_W'(1);
    localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(1) << (ENTRY_FRAC - 1);
    localparam logic signed [PROD_W-1:0] RND_NEG = RND_POS - PROD_W'(1);

    // Credit count: items in the pipeline plus items in the result queue
    logic [OUT_AW:0]  credit_reg;
    logic [OUT_AW:0]  credit_next;
    logic             take;
    logic             give;
    logic [PIPE_LEN-1:0] vld_reg;

    // Matrix entries
    logic signed [ENTRY_W-1:0] ent [ROWS][ROWS];

    // Stage 1: scale partial products
    logic [HI_W-1:0]   s1_hi_reg [LANES];
    logic [LO_W-1:0]   s1_lo_reg [LANES];
    logic [LANES-1:0]  s1_neg_reg;
    logic              s1_zero_reg;
    // Stage 2: rounded local magnitude and overflow
    logic [COORD_WIDTH-1:0] s2_r_reg [LANES];
    logic [LANES-1:0]  s2_neg_reg;
    logic              s2_ovf_reg;
    // Stage 3: signed local point
    logic signed [COORD_WIDTH-1:0] s3_loc_reg [LANES];
    logic              s3_ovf_reg;
    // Stage 4: matrix products
    logic signed [PROD_W-1:0] s4_prod_reg [ROWS][LANES];
    logic              s4_ovf_reg;
    // Stage 5: rounded terms
    logic signed [TERM_W-1:0] s5_term_reg [ROWS][LANES];
    logic              s5_ovf_reg;
    // Stage 6: clip accumulators
    logic signed [ACC_W-1:0] s6_acc_reg [ROWS];
    logic              s6_ovf_reg;
    // Stage 7: classification, clip magnitudes
    logic [COORD_WIDTH-1:0] s7_mag_reg [LANES];
    logic [LANES-1:0]  s7_neg_reg;
    logic [COORD_WIDTH-1:0] s7_w_reg;
    logic [1:0]        s7_code_reg;
    // Divider chain; index 0 is the setup stage
    logic [NUM_W-1:0]  d_rem_reg  [DIV_STEPS+1][LANES];
    logic [Q_W-1:0]    d_q_reg    [DIV_STEPS+1][LANES];
    logic [COORD_WIDTH-1:0] d_w_reg [DIV_STEPS+1];
    logic [LANES-1:0]  d_neg_reg  [DIV_STEPS+1];
    logic              d_out_reg  [DIV_STEPS+1];
    logic [1:0]        d_code_reg [DIV_STEPS+1];

    // Result queue
    result_t           out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg;
    logic [OUT_AW-1:0] rd_ptr_reg;
    logic [OUT_AW:0]   fill_reg;
    logic [OUT_AW:0]   fill_next;
    logic              out_wr;
    logic              out_rd;
    result_t           fin;

    function automatic logic [SCR_W-1:0] to_screen(input logic signed [Q_W+1:0] s);
        logic [Q_W+1:0] half;
        half = Q_W'(0) + (Q_W+2)'(s >>> 1);
        if (s <= 0)
        begin
            to_screen = '0;
        end
        else if (half > (Q_W+2)'({SCR_W{1'b1}}))
        begin
            to_screen = '1;
        end
        else
        begin
            to_screen = half[SCR_W-1:0];
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            for (int j = 0; j < ROWS; j++)
            begin
                ent[i][j] = cfg.row[i][ENTRY_W*j +: ENTRY_W];
            end
        end
    end

    // Issue from the queue only when the result queue has room reserved
    assign take    = q_valid && (credit_reg != (OUT_AW+1)'(OUT_DEPTH));
    assign q_ready = take;
    assign out_wr  = vld_reg[PIPE_LEN-1];
    assign out_rd  = pop && !empty;
    assign give    = out_rd;

    always_comb
    begin
        credit_next = credit_reg;
        if (take && !give)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!take && give)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            vld_reg    <= {vld_reg[PIPE_LEN-2:0], take};
        end
    end

    // Arithmetic stages; the pipeline never stalls
    always_ff @(posedge clk)
    begin
        // Stage 1
        for (int l = 0; l < LANES; l++)
        begin
            s1_hi_reg[l] <= HI_W'(q_data.mag[l][DIFF_W-1:SPLIT_W]) * HI_W'(cfg.scale);
            s1_lo_reg[l] <= LO_W'(q_data.mag[l][SPLIT_W-1:0]) * LO_W'(cfg.scale);
        end
        s1_neg_reg  <= q_data.neg;
        s1_zero_reg <= q_data.szero;

        // Stage 2
        begin
            logic [SPROD_W-1:0] sum;
            logic any;
            any = s1_zero_reg;
            for (int l = 0; l < LANES; l++)
            begin
                sum = {s1_hi_reg[l], {SPLIT_W{1'b0}}} + SPROD_W'(s1_lo_reg[l]) + SCALE_RND;
                s2_r_reg[l] <= sum[SCALE_FRAC +: COORD_WIDTH];
                if (sum[SPROD_W-1:SCALE_FRAC] > (SPROD_W-SCALE_FRAC)'(LIM_U))
                begin
                    any = 1'b1;
                end
            end
            s2_ovf_reg <= any;
        end
        s2_neg_reg <= s1_neg_reg;

        // Stage 3
        for (int l = 0; l < LANES; l++)
        begin
            s3_loc_reg[l] <= s2_neg_reg[l] ? (COORD_WIDTH'(0) - s2_r_reg[l]) : s2_r_reg[l];
        end
        s3_ovf_reg <= s2_ovf_reg;

        // Stage 4
        for (int i = 0; i < ROWS; i++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s4_prod_reg[i][l] <= PROD_W'(ent[i][l]) * PROD_W'(s3_loc_reg[l]);
            end
        end
        s4_ovf_reg <= s3_ovf_reg;

        // Stage 5: round half away from zero
        for (int i = 0; i < ROWS; i++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic signed [PROD_W-1:0] biased;
                biased = s4_prod_reg[i][l] +
                         (s4_prod_reg[i][l][PROD_W-1] ? RND_NEG : RND_POS);
                s5_term_reg[i][l] <= biased[PROD_W-1:ENTRY_FRAC];
            end
        end
        s5_ovf_reg <= s4_ovf_reg;

        // Stage 6
        for (int i = 0; i < ROWS; i++)
        begin
            s6_acc_reg[i] <= ACC_W'(s5_term_reg[i][0]) + ACC_W'(s5_term_reg[i][1]) +
                             ACC_W'(s5_term_reg[i][2]) + (ACC_W'(ent[i][3]) <<< 4);
        end
        s6_ovf_reg <= s5_ovf_reg;

        // Stage 7: overflow and behind-camera checks
        begin
            logic covf;
            covf = 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                if (s6_acc_reg[i] > LIM_S || s6_acc_reg[i] < -LIM_S)
                begin
                    covf = 1'b1;
                end
            end
            if (s6_ovf_reg || covf)
            begin
                s7_code_reg <= REJ_OVERFLOW;
            end
            else if (s6_acc_reg[3] <= W_TOL)
            begin
                s7_code_reg <= REJ_BEHIND;
            end
            else
            begin
                s7_code_reg <= REJ_NONE;
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            s7_neg_reg[l] <= s6_acc_reg[l][ACC_W-1];
            s7_mag_reg[l] <= s6_acc_reg[l][ACC_W-1] ?
                             (COORD_WIDTH'(0) - s6_acc_reg[l][COORD_WIDTH-1:0]) :
                             s6_acc_reg[l][COORD_WIDTH-1:0];
        end
        s7_w_reg <= s6_acc_reg[3][COORD_WIDTH-1:0];

        // Stage 8: range check against the frustum, divider setup
        begin
            logic [NUM_W-1:0] wlim;
            logic             outside;
            wlim    = (NUM_W'(s7_w_reg) << FRAC_BITS) + (NUM_W'(s7_w_reg) << 1);
            outside = 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                d_rem_reg[0][l] <= {s7_mag_reg[l], {FRAC_BITS{1'b0}}};
                d_q_reg[0][l]   <= '0;
                if ({s7_mag_reg[l], {FRAC_BITS{1'b0}}} >= wlim)
                begin
                    outside = 1'b1;
                end
            end
            d_out_reg[0] <= outside;
        end
        d_w_reg[0]    <= s7_w_reg;
        d_neg_reg[0]  <= s7_neg_reg;
        d_code_reg[0] <= s7_code_reg;

        // Divider: one quotient bit per stage, most significant first
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [NUM_W-1:0] dv;
                dv = NUM_W'(d_w_reg[s]) << (DIV_STEPS - 1 - s);
                if (d_rem_reg[s][l] >= dv)
                begin
                    d_rem_reg[s+1][l] <= d_rem_reg[s][l] - dv;
                    d_q_reg[s+1][l]   <= d_q_reg[s][l] | (Q_W'(1) << (DIV_STEPS - 1 - s));
                end
                else
                begin
                    d_rem_reg[s+1][l] <= d_rem_reg[s][l];
                    d_q_reg[s+1][l]   <= d_q_reg[s][l];
                end
            end
            d_w_reg[s+1]    <= d_w_reg[s];
            d_neg_reg[s+1]  <= d_neg_reg[s];
            d_out_reg[s+1]  <= d_out_reg[s];
            d_code_reg[s+1] <= d_code_reg[s];
        end
    end

    // Final code and viewport mapping
    always_comb
    begin
        logic signed [Q_W+1:0] one;
        logic signed [Q_W+1:0] qx;
        logic signed [Q_W+1:0] qy;
        logic [1:0]            code;
        one = (Q_W+2)'(1) << FRAC_BITS;
        qx  = (Q_W+2)'(d_q_reg[DIV_STEPS][0]);
        qy  = (Q_W+2)'(d_q_reg[DIV_STEPS][1]);
        if (d_neg_reg[DIV_STEPS][0])
        begin
            qx = -qx;
        end
        if (d_neg_reg[DIV_STEPS][1])
        begin
            qy = -qy;
        end
        if (d_code_reg[DIV_STEPS] != REJ_NONE)
        begin
            code = d_code_reg[DIV_STEPS];
        end
        else if (d_out_reg[DIV_STEPS])
        begin
            code = REJ_OUTSIDE;
        end
        else
        begin
            code = REJ_NONE;
        end
        fin.code    = code;
        fin.visible = (code == REJ_NONE);
        fin.u       = (code == REJ_NONE) ? to_screen(one + qx) : '0;
        fin.v       = (code == REJ_NONE) ? to_screen(one - qy) : '0;
    end

    // Result queue
    assign empty = (fill_reg == '0);
    assign head  = out_mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (out_wr && !out_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!out_wr && out_rd)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (out_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_mem[wr_ptr_reg] <= fin;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/perspective_point_projector.sv -----
// Top level of the perspective point projector: register bank and block wiring.
//
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------------------
//  input     push / full             point_x, point_y, point_z
//  result    empty / pop             visible, reject_code, screen_u, screen_v
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One point per cycle sustained while results are popped; a point passes the
// front register, the queue and 25 back stages (8 arithmetic, 17 divider bit
// steps) before reaching the result ports. The divider chain sets the latency.
// Reset loads the identity matrix, zero origin and unit scale.
// A stalled result side fills the 32-entry result queue; the back pipeline
// issues only against free entries, then the queue and front back up to full.
`default_nettype none

module perspective_point_projector
    import ppp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [COORD_WIDTH-1:0] point_x,
    input  wire logic [COORD_WIDTH-1:0] point_y,
    input  wire logic [COORD_WIDTH-1:0] point_z,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        visible,
    output logic [1:0]                  reject_code,
    output logic [SCR_W-1:0]            screen_u,
    output logic [SCR_W-1:0]            screen_v,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic        front_ready;
    logic        fq_valid;
    logic        fq_ready;
    front_item_t fq_data;
    logic        qb_valid;
    logic        qb_ready;
    front_item_t qb_data;
    result_t     head;
    logic [LANES-1:0][COORD_WIDTH-1:0] point;

    assign cfg_ready = 1'b1;
    assign full      = !front_ready;
    assign point     = {point_z, point_y, point_x};

    // Register bank; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row[0] <= CFG_DATA_W'(4096);
            cfg_reg.row[1] <= CFG_DATA_W'(4096) << 16;
            cfg_reg.row[2] <= CFG_DATA_W'(4096) << 32;
            cfg_reg.row[3] <= CFG_DATA_W'(4096) << 48;
            cfg_reg.org    <= '0;
            cfg_reg.scale  <= SCALE_W'(1) << SCALE_FRAC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW0:  cfg_reg.row[0] <= cfg_data;
                REG_ROW1:  cfg_reg.row[1] <= cfg_data;
                REG_ROW2:  cfg_reg.row[2] <= cfg_data;
                REG_ROW3:  cfg_reg.row[3] <= cfg_data;
                REG_ORG_X: cfg_reg.org[0] <= cfg_data[COORD_WIDTH-1:0];
                REG_ORG_Y: cfg_reg.org[1] <= cfg_data[COORD_WIDTH-1:0];
                REG_ORG_Z: cfg_reg.org[2] <= cfg_data[COORD_WIDTH-1:0];
                REG_SCALE: cfg_reg.scale  <= cfg_data[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    ppp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .in_ready (front_ready),
        .point    (point),
        .cfg      (cfg_reg),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    ppp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    ppp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign visible     = head.visible;
    assign reject_code = head.code;
    assign screen_u    = head.u;
    assign screen_v    = head.v;

    // A full input side means the front stage holds a beat the queue refused
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (fq_valid && !fq_ready))
        else $error("full raised without a held front beat");

    // The visible flag agrees with the reject code
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (visible == (reject_code == REJ_NONE)))
        else $error("visible flag disagrees with reject code");

    // Rejected points carry zero viewport coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reject_code != REJ_NONE) |-> (screen_u == '0 && screen_v == '0))
        else $error("rejected point with nonzero viewport position");

endmodule

`default_nettype wire
